/* hdl/bis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, op and status codes and defaults for the bounded stack.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int DEF_DEPTH      = 256;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic [INDEX_W-1:0]        found_index;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic                      is_full;
    } rsp_t;

endpackage

/* hdl/bis_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int DEPTH      = bis_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = bis_pkg::DEF_DATA_WIDTH,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/bounded_int_stack_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_int_stack_with_search
// LIFO stack of words in a synchronous RAM with a top-down search.
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken at a clock edge with start high and busy
//   low; cmd carries op and value. each command gives one result on rsp,
//   marked by done for exactly one cycle; the receiver cannot stall it.
//   the capacity register is written over cfg_valid/cfg_ready/cfg_data,
//   always ready; the user must write it only while no command is in flight,
//   which the block itself does not enforce.
// from the accepting edge, push, clear, failed ops and unused codes go
// straight to the result register; pop and peek pass the RAM read
// register, then the result register; search reads and compares one entry
// per cycle from the top down, stopping at the first match.
// busy is high while a read or scan is in flight; a new command can be
// taken in the cycle its predecessor's result is shown.
// reset: count clears to zero and capacity returns to 256; the RAM is not
// cleared, since only entries below count are ever read.
// ----------------------------------------------------------------------------
module bounded_int_stack_with_search #(
    parameter int DEPTH      = bis_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = bis_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bis_pkg::cmd_t                 cmd,
    output logic                          done,
    output bis_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bis_pkg::COUNT_W-1:0]   cfg_data
);

    import bis_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [COUNT_W-1:0]    cap_reg;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  done_reg, done_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] in_key;
    logic [CW-1:0]         count_m1;
    logic [AW-1:0]         top_addr;
    logic [WW-1:0]         cap_w, cap_eff;
    logic                  full_now;

    logic                  fin;
    logic [STATUS_W-1:0]   fin_status;
    logic [VALUE_W-1:0]    fin_data;
    logic [INDEX_W-1:0]    fin_found;
    logic [CW-1:0]         fin_count;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    assign in_key   = DATA_WIDTH'($unsigned(cmd.value));
    assign count_m1 = count_reg - 1'b1;
    assign top_addr = count_m1[AW-1:0];

    // capacity above the RAM size acts as the RAM size
    assign cap_w    = WW'(cap_reg);
    assign cap_eff  = (cap_w > WW'(DEPTH)) ? WW'(DEPTH) : cap_w;
    assign full_now = (WW'(count_reg) >= cap_eff);

    bis_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = top_addr;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_data   = '0;
        fin_found  = '0;
        fin_count  = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            fin = 1'b1;
                            if (full_now)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fin_count = CW'(count_reg + 1'b1);
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                op_next    = cmd.op;
                                state_next = S_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fin       = 1'b1;
                            fin_count = '0;
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                addr_next  = top_addr;
                                key_next   = in_key;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                fin      = 1'b1;
                fin_data = VALUE_W'(rd_data);
                if (op_reg == OP_POP)
                begin
                    fin_count = count_m1;
                end
            end
            S_SCAN:
            begin
                // rd_data holds the entry at addr_reg
                if (rd_data == key_reg)
                begin
                    fin       = 1'b1;
                    fin_found = INDEX_W'(addr_reg);
                end
                else if (addr_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg - 1'b1;
                    addr_next = addr_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next           = S_IDLE;
            count_next           = fin_count;
            done_next            = 1'b1;
            rsp_next.status      = fin_status;
            rsp_next.data        = fin_data;
            rsp_next.found_index = fin_found;
            rsp_next.count       = COUNT_W'(fin_count);
            rsp_next.is_empty    = (fin_count == '0);
            rsp_next.is_full     = (WW'(fin_count) >= cap_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        addr_reg <= addr_next;
        rsp_reg  <= rsp_next;
    end

    // count never passes the RAM size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(count_reg) <= WW'(DEPTH))
        else $error("stack count beyond depth");

    // a result follows an accepted command or an in-flight read or scan
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept) || $past(state_reg != S_IDLE))
        else $error("result without a command");

    // the scan only touches entries below count
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(addr_reg) < count_reg))
        else $error("scan address above top");

    // a push grows the count by one on the next cycle
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == CW'($past(count_reg) + 1'b1)) && done_reg)
        else $error("push did not grow count");

    // after the read state, done is high and the block is back in idle
    a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> done_reg && (state_reg == S_IDLE))
        else $error("read result missing");

endmodule

/* tb/stack_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// Watches the command, result and capacity channels of the bounded stack,
// keeps a shadow copy of the stack, and checks each result field by field
// against the expected response queued when its command was accepted.
// ----------------------------------------------------------------------------
module stack_checker #(
    parameter int DEPTH = bis_pkg::DEF_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  bis_pkg::cmd_t               cmd,
    input  logic                        done,
    input  bis_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [bis_pkg::COUNT_W-1:0] cfg_data,
    output int                          errors,
    output int                          outstanding
);
    import bis_pkg::*;

    logic [VALUE_W-1:0] shadow_words [DEPTH];
    int                 shadow_depth;
    logic [COUNT_W-1:0] shadow_cap;
    rsp_t               pending_rsp [$];
    rsp_t               want;

    initial errors = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("%0t ns  error: %s got %0h want %0h", $time, what, got, exp_val);
        errors++;
    endtask

    // applies one command to the shadow stack and returns its response
    function automatic rsp_t apply_stack_op(input cmd_t c);
        rsp_t r;
        int   lim;
        int   i;
        r = '0;
        lim = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
        r.status = ST_OK;
        case (c.op)
            OP_PUSH:
            begin
                if (shadow_depth >= lim)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_depth] = c.value;
                    shadow_depth++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (shadow_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data = shadow_words[shadow_depth - 1];
                    if (c.op == OP_POP)
                        shadow_depth--;
                end
            end
            OP_CLEAR:
                shadow_depth = 0;
            OP_SEARCH:
            begin
                // top-down scan, first hit wins
                r.status = ST_NOTFOUND;
                i = shadow_depth;
                while (i > 0 && r.status == ST_NOTFOUND)
                begin
                    i--;
                    if (shadow_words[i] == c.value)
                    begin
                        r.status = ST_OK;
                        r.found_index = i[INDEX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.count = shadow_depth[COUNT_W-1:0];
        r.is_empty = (shadow_depth == 0);
        r.is_full = (shadow_depth >= lim);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_depth = 0;
            shadow_cap = CAP_RESET;
            pending_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                    flag_mismatch("result with no command pending", rsp.count, 0);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch("status", rsp.status, want.status);
                    if (rsp.data !== want.data)
                        flag_mismatch("data", rsp.data, want.data);
                    if (rsp.found_index !== want.found_index)
                        flag_mismatch("found_index", rsp.found_index, want.found_index);
                    if (rsp.count !== want.count)
                        flag_mismatch("count", rsp.count, want.count);
                    if (rsp.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", rsp.is_empty, want.is_empty);
                    if (rsp.is_full !== want.is_full)
                        flag_mismatch("is_full", rsp.is_full, want.is_full);
                end
            end
            if (cfg_valid && cfg_ready)
                shadow_cap = cfg_data;
            if (start && !busy)
                pending_rsp.push_back(apply_stack_op(cmd));
            outstanding <= pending_rsp.size();
        end
    end

endmodule

/* tb/bounded_int_stack_with_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_int_stack_with_search_tb
// Drives directed and random stack commands through several capacity
// settings with random idle gaps; the checker beside the block does all
// prediction and comparison, this module only gives the verdict.
// ----------------------------------------------------------------------------
module bounded_int_stack_with_search_tb;
    import bis_pkg::*;

    localparam int DEPTH = DEF_DEPTH;
    localparam logic [OP_W-1:0] OP_NONE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_NONE_HI = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    int                 errors;
    int                 outstanding;
    bit                 burst;

    bounded_int_stack_with_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DEF_DATA_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stack_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("bounded_int_stack_with_search: mismatch");
        $finish;
    end

    task automatic idle_gap();
        int n;
        if (burst)
            n = 0;
        else
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = 0;
                6, 7, 8:          n = $urandom_range(1, 3);
                default:          n = $urandom_range(8, 40);
            endcase
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one command transaction, then maybe an idle gap
    task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        start <= 1'b1;
        cmd <= '{op: op, value: value};
        do @(posedge clk); while (busy);
        if ($urandom_range(0, 29) == 0)
            burst = ~burst;
        idle_gap();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // small pool half the time so searches hit and duplicates occur
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return VALUE_W'($signed($urandom_range(0, 15)) - 8);
            5, 6:
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int w_push, input int w_pop,
                                                 input int w_peek, input int w_search,
                                                 input int w_clear);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_push)
            return OP_PUSH;
        r -= w_push;
        if (r < w_pop)
            return OP_POP;
        r -= w_pop;
        if (r < w_peek)
            return OP_PEEK;
        r -= w_peek;
        if (r < w_search)
            return OP_SEARCH;
        r -= w_search;
        if (r < w_clear)
            return OP_CLEAR;
        return OP_W'($urandom_range(OP_NONE_LO, OP_NONE_HI));
    endfunction

    task automatic run_phase(input logic [COUNT_W-1:0] cap, input int n_items,
                             input int w_push, input int w_pop, input int w_peek,
                             input int w_search, input int w_clear);
        drain_results();
        write_capacity(cap);
        repeat (n_items)
        begin
            issue_cmd(pick_op(w_push, w_pop, w_peek, w_search, w_clear), pick_value());
            // occasionally hold off until the block has answered everything
            if ($urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        burst = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(CAP_RESET);

        // directed: empty stack, extremes, duplicates, unused codes, clear
        issue_cmd(OP_POP, 32'h0);
        issue_cmd(OP_PEEK, 32'h0);
        issue_cmd(OP_SEARCH, 32'h0);
        issue_cmd(OP_PUSH, 32'h7fff_ffff);
        issue_cmd(OP_PUSH, 32'h8000_0000);
        issue_cmd(OP_PUSH, 32'h0000_0000);
        issue_cmd(OP_PUSH, 32'hffff_ffff);
        issue_cmd(OP_PUSH, 32'h7fff_ffff);
        issue_cmd(OP_PEEK, 32'h0);
        issue_cmd(OP_SEARCH, 32'h7fff_ffff);
        issue_cmd(OP_SEARCH, 32'h8000_0000);
        issue_cmd(OP_SEARCH, 32'h0000_3039);
        issue_cmd(OP_NONE_LO, 32'h1234_5678);
        issue_cmd(OP_NONE_LO + 3'd1, 32'hffff_ffff);
        issue_cmd(OP_NONE_HI, 32'h8000_0000);
        issue_cmd(OP_POP, 32'h0);
        issue_cmd(OP_POP, 32'h0);
        issue_cmd(OP_POP, 32'h0);
        issue_cmd(OP_CLEAR, 32'h0);
        issue_cmd(OP_POP, 32'h0);
        issue_cmd(OP_SEARCH, 32'hffff_ffff);
        issue_cmd(OP_PUSH, 32'h5555_5555);
        issue_cmd(OP_PUSH, 32'haaaa_aaaa);
        issue_cmd(OP_PEEK, 32'h0);
        issue_cmd(OP_POP, 32'h0);

        // zero capacity with an entry still held, then small sizes
        run_phase(9'd0, 20, 40, 25, 10, 20, 3);
        run_phase(9'd1, 30, 45, 20, 10, 20, 3);
        run_phase(9'd5, 40, 45, 20, 10, 20, 3);
        run_phase(9'd17, 50, 50, 15, 10, 20, 3);
        // fill the whole memory and run into full
        run_phase(9'd256, 320, 88, 3, 3, 4, 0);
        // capacity dropped below the count held
        run_phase(9'd3, 30, 30, 30, 10, 28, 0);
        // above DEPTH saturates
        run_phase(9'd511, 40, 70, 5, 5, 18, 0);
        run_phase(COUNT_W'($urandom_range(0, DEPTH)), 30, 45, 20, 10, 20, 3);
        run_phase(COUNT_W'($urandom_range(0, DEPTH)), 30, 45, 20, 10, 20, 3);

        drain_results();
        repeat (DEPTH + 20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("bounded_int_stack_with_search: match");
        else
            $display("bounded_int_stack_with_search: mismatch");
        $finish;
    end

endmodule

/* bounded_int_stack_with_search.f */
hdl/bis_pkg.sv
hdl/bis_ram.sv
hdl/bounded_int_stack_with_search.sv
tb/stack_checker.sv
tb/bounded_int_stack_with_search_tb.sv
